FILE: design/slc_pkg.sv
// Shared constants, opcodes and sprite size tables for the sprite line compositor.
// Used by the channel interfaces and by the top level; depends on nothing.
package slc_pkg;

    localparam int LINE_WIDTH      = 240;
    localparam int SCREEN_HEIGHT   = 160;
    localparam int CHAR_BYTES      = 32768;
    localparam int PALETTE_ENTRIES = 256;

    localparam int LINE_AW = $clog2(LINE_WIDTH);
    localparam int CHAR_AW = $clog2(CHAR_BYTES);
    localparam int PAL_AW  = $clog2(PALETTE_ENTRIES);

    localparam int OP_W    = 3;
    localparam int ADDR_W  = 15;
    localparam int PIX_W   = 19;
    localparam int ATTR_W  = 16;
    localparam int LINE_W  = 8;
    localparam int AFF_W   = 16;

    localparam logic [OP_W-1:0] OP_WR_PAL   = 3'd0;
    localparam logic [OP_W-1:0] OP_WR_CHR   = 3'd1;
    localparam logic [OP_W-1:0] OP_WR_LINE  = 3'd2;
    localparam logic [OP_W-1:0] OP_RD_PIX   = 3'd3;
    localparam logic [OP_W-1:0] OP_DRAW     = 3'd4;
    localparam logic [OP_W-1:0] OP_DRAW_AFF = 3'd5;

    localparam logic [1:0] REG_ONE_DIM = 2'd0;
    localparam logic [1:0] REG_MOS_H   = 2'd1;
    localparam logic [1:0] REG_MOS_V   = 2'd2;

    localparam logic [1:0] MODE_SEMI   = 2'd1;
    localparam logic [1:0] MODE_WINDOW = 2'd2;
    localparam logic [1:0] SHAPE_BAD   = 2'd3;

    // Sprite width in tiles, as a power of two, by shape and size code.
    function automatic logic [1:0] size_w_log2(input logic [1:0] shape, input logic [1:0] sz);
        logic [1:0] r;
        case (shape)
            2'd0: r = sz;
            2'd1: r = (sz == 2'd0) ? 2'd1 : ((sz == 2'd3) ? 2'd3 : 2'd2);
            2'd2: r = (sz == 2'd0) ? 2'd0 : 2'(sz - 2'd1);
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    // Sprite height in tiles, as a power of two, by shape and size code.
    function automatic logic [1:0] size_h_log2(input logic [1:0] shape, input logic [1:0] sz);
        logic [1:0] r;
        case (shape)
            2'd0: r = sz;
            2'd1: r = (sz == 2'd0) ? 2'd0 : 2'(sz - 2'd1);
            2'd2: r = (sz == 2'd0) ? 2'd1 : ((sz == 2'd3) ? 2'd3 : 2'd2);
            default: r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

FILE: design/slc_if.sv
// Request and result channel interfaces of the sprite line compositor.
// Depends on slc_pkg for the field widths.
interface slc_req_if import slc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          op;
    logic [ADDR_W-1:0]        address;
    logic [PIX_W-1:0]         write_data;
    logic [ATTR_W-1:0]        attr_shape;
    logic [ATTR_W-1:0]        attr_position;
    logic [ATTR_W-1:0]        attr_tile;
    logic [LINE_W-1:0]        scan_line;
    logic signed [AFF_W-1:0]  affine_pa;
    logic signed [AFF_W-1:0]  affine_pb;
    logic signed [AFF_W-1:0]  affine_pc;
    logic signed [AFF_W-1:0]  affine_pd;

    modport source (output valid, op, address, write_data, attr_shape, attr_position,
                    attr_tile, scan_line, affine_pa, affine_pb, affine_pc, affine_pd,
                    input ready);
    modport sink   (input valid, op, address, write_data, attr_shape, attr_position,
                    attr_tile, scan_line, affine_pa, affine_pb, affine_pc, affine_pd,
                    output ready);
endinterface

interface slc_rsp_if import slc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_word;

    modport source (output valid, pixel_word, input ready);
    modport sink   (input valid, pixel_word, output ready);
endinterface

FILE: design/sprite_line_compositor.sv
// Sprite line compositor top level: palette, tile and line memories plus the draw sequencer.
// Depends on slc_pkg and the slc_req_if / slc_rsp_if channel interfaces.
//
//   channel   direction  handshake        contents
//   i_req     in         valid/ready      op, address, write_data, attributes, line, matrix
//   o_rsp     out        valid/ready      pixel_word (read requests only)
//   APB       in         psel/penable     one_dim_mapping, mosaic_horizontal, mosaic_vertical
//
// After reset a clearing pass zeroes all three memories, one entry per cycle, before the
// first request is taken. A read waits while o_rsp still holds an untaken result. A draw
// runs its setup states (plus the matrix products for affine and a remainder pass for
// mosaic), then each drawn pixel does a tile fetch, a palette lookup and a line buffer
// read-modify-write; a skipped pixel only advances the position.
module sprite_line_compositor import slc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    slc_req_if.sink     i_req,
    slc_rsp_if.source   o_rsp
);

    localparam int CX_W = 28;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_RD, S_CHK, S_DIV, S_SET, S_AFF, S_PIX, S_CHR, S_PLT
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic       r_one_dim;
    logic [3:0] r_mos_h;
    logic [3:0] r_mos_v;

    // Memories.
    logic [15:0]      r_pal_mem  [PALETTE_ENTRIES];
    logic [7:0]       r_chr_mem  [CHAR_BYTES];
    logic [PIX_W-1:0] r_line_mem [LINE_WIDTH];
    logic [15:0]      r_pal_q;
    logic [7:0]       r_chr_q;
    logic [PIX_W-1:0] r_line_q;

    // Latched request.
    logic [15:0]        r_a0, r_a1, r_a2;
    logic [7:0]         r_line;
    logic signed [15:0] r_pa, r_pb, r_pc, r_pd;
    logic               r_aff;

    // Draw working state.
    logic [CHAR_AW-1:0]   r_clr;
    logic [7:0]           r_linem;
    logic [4:0]           r_mos_w;
    logic [3:0]           r_pmod;
    logic [5:0]           r_row;
    logic signed [10:0]   r_dy;
    logic signed [CX_W-1:0] r_cx, r_cy;
    logic signed [26:0]   r_prod;
    logic [2:0]           r_mstep;
    logic [7:0]           r_i;
    logic [LINE_AW-1:0]   r_pos;
    logic                 r_sx0;
    logic                 r_copy;
    logic                 r_idx_nz;
    logic                 r_rd_ok;

    // Shared remainder unit.
    logic [7:0] r_dnd;
    logic [3:0] r_rem;
    logic [4:0] r_dvs;
    logic [2:0] r_dcnt;
    logic       r_dsel;

    logic             r_out_valid;
    logic [PIX_W-1:0] r_out;

    // Configuration port.
    logic cfg_we;
    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite & pready;

    always_comb begin
        case (paddr[3:2])
            REG_ONE_DIM: prdata = {31'b0, r_one_dim};
            REG_MOS_H:   prdata = {28'b0, r_mos_h};
            REG_MOS_V:   prdata = {28'b0, r_mos_v};
            default:     prdata = 32'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_one_dim <= 1'b0;
            r_mos_h   <= 4'd0;
            r_mos_v   <= 4'd0;
        end else if (cfg_we) begin
            case (paddr[3:2])
                REG_ONE_DIM: r_one_dim <= pwdata[0];
                REG_MOS_H:   r_mos_h   <= pwdata[3:0];
                REG_MOS_V:   r_mos_v   <= pwdata[3:0];
                default:     ;
            endcase
        end
    end

    // Sprite geometry from the latched attribute words.
    logic [1:0]  mode, shape, sz, wl, hl;
    logic        dbl, deep, hflip, vflip, skip;
    logic [7:0]  fw, fh;
    logic [6:0]  w8, h8;
    logic signed [10:0] yoff, ytop_end, line_s, linem_s;
    logic signed [8:0]  xoff;
    logic [1:0]  prio;
    logic        semi;

    assign mode  = r_a0[11:10];
    assign shape = r_a0[15:14];
    assign sz    = r_a1[15:14];
    assign deep  = r_a0[13];
    assign hflip = r_a1[12];
    assign vflip = r_a1[13];
    assign dbl   = r_aff & r_a0[9];
    assign wl    = size_w_log2(shape, sz);
    assign hl    = size_h_log2(shape, sz);
    assign w8    = 7'd8 << wl;
    assign h8    = 7'd8 << hl;
    assign fw    = {1'b0, w8} << dbl;
    assign fh    = {1'b0, h8} << dbl;
    assign skip  = (mode == MODE_WINDOW) || (shape == SHAPE_BAD) || (!r_aff && r_a0[9]);
    assign yoff  = (r_a0[7:0] > 8'(SCREEN_HEIGHT)) ? {3'b111, r_a0[7:0]} : {3'b000, r_a0[7:0]};
    assign ytop_end = yoff + $signed({3'b000, fh});
    assign line_s   = $signed({3'b000, r_line});
    assign linem_s  = $signed({3'b000, r_linem});
    assign xoff  = $signed(r_a1[8:0]);
    assign prio  = r_a2[11:10];
    assign semi  = (mode == MODE_SEMI);

    // Remainder step: one dividend bit per cycle.
    logic [4:0] d_t;
    logic [3:0] d_rem_n;
    assign d_t     = {r_rem, r_dnd[7]};
    assign d_rem_n = (d_t >= r_dvs) ? 4'(d_t - r_dvs) : d_t[3:0];

    // Regular row after clamp and flip.
    logic signed [10:0] row_raw;
    logic [5:0] row_c;
    assign row_raw = linem_s - yoff;
    always_comb begin
        row_c = row_raw[10] ? 6'd0 : row_raw[5:0];
        if (vflip) begin
            row_c = 6'(h8 - 7'd1 - {1'b0, row_c});
        end
    end

    // Affine setup multiplier, one product per cycle.
    logic signed [10:0] mul_a;
    logic signed [15:0] mul_b;
    always_comb begin
        mul_a = r_mstep[0] ? r_dy : $signed({4'b0, fw[7:1]});
        case (r_mstep[1:0])
            2'd0:    mul_b = r_pa;
            2'd1:    mul_b = r_pb;
            2'd2:    mul_b = r_pc;
            default: mul_b = r_pd;
        endcase
    end

    // Per-pixel position and sample coordinates.
    logic signed [10:0] pos;
    logic [10:0] pos_u;
    logic        on, inb, do_plot, copy;
    logic signed [CX_W-9:0] ix, iy;
    logic [5:0]  sx, sy;
    logic [7:0]  sx_reg;
    logic [17:0] row_off, in_off, caddr;
    logic [4:0]  pmod_inc;

    assign pos   = {{2{xoff[8]}}, xoff} + $signed({3'b000, r_i});
    assign pos_u = pos;
    assign on    = !pos_u[10] && (pos_u < 11'(LINE_WIDTH));
    assign ix    = r_cx[CX_W-1:8];
    assign iy    = r_cy[CX_W-1:8];
    assign inb   = !ix[CX_W-9] && (ix < $signed({{(CX_W-15){1'b0}}, w8})) &&
                   !iy[CX_W-9] && (iy < $signed({{(CX_W-15){1'b0}}, h8}));
    assign sx_reg = hflip ? 8'(fw - 8'd1 - r_i) : r_i;
    assign sx    = r_aff ? ix[5:0] : sx_reg[5:0];
    assign sy    = r_aff ? iy[5:0] : r_row;
    assign do_plot = on && (!r_aff || inb);
    assign copy  = (r_mos_w != 5'd0) && (r_pmod != 4'd0);
    assign pmod_inc = {1'b0, r_pmod} + 5'd1;

    always_comb begin
        if (r_one_dim) begin
            row_off = {15'b0, sy[5:3]} << ({3'b0, wl} + (deep ? 5'd6 : 5'd5));
        end else begin
            row_off = {15'b0, sy[5:3]} << 10;
        end
        if (deep) begin
            in_off = ({15'b0, sx[5:3]} << 6) + ({15'b0, sy[2:0]} << 3) + {15'b0, sx[2:0]};
        end else begin
            in_off = ({15'b0, sx[5:3]} << 5) + ({15'b0, sy[2:0]} << 2) + {16'b0, sx[2:1]};
        end
        caddr = {3'b0, r_a2[9:0], 5'b0} + row_off + in_off;
    end

    // Pixel index and merge.
    logic [7:0]       idx;
    logic [PIX_W-1:0] cur, plot_data;
    logic             plot_we;
    assign idx = deep ? r_chr_q : {4'b0, (r_sx0 ? r_chr_q[7:4] : r_chr_q[3:0])};
    assign cur = r_line_q;

    always_comb begin
        plot_we   = 1'b0;
        plot_data = cur;
        if (r_copy) begin
            plot_we = 1'b1;
        end else if (r_idx_nz) begin
            if ((prio < cur[17:16]) || !cur[15]) begin
                plot_we   = 1'b1;
                plot_data = {semi, prio, 1'b1, r_pal_q[14:0]};
            end
        end else if (prio < cur[17:16]) begin
            plot_we   = 1'b1;
            plot_data = {cur[18], prio, cur[15:0]};
        end
    end

    // Memory port muxing.
    logic acc;
    logic               chr_we, pal_we, line_we;
    logic [CHAR_AW-1:0] chr_waddr, chr_raddr;
    logic [7:0]         chr_wdata;
    logic [PAL_AW-1:0]  pal_waddr, pal_raddr;
    logic [15:0]        pal_wdata;
    logic [LINE_AW-1:0] line_waddr, line_raddr;
    logic [PIX_W-1:0]   line_wdata;
    logic               addr_in_line;

    assign i_req.ready  = (r_state == S_IDLE);
    assign acc          = i_req.valid && i_req.ready;
    assign addr_in_line = (i_req.address < ADDR_W'(LINE_WIDTH));
    assign chr_raddr    = caddr[CHAR_AW-1:0];
    assign pal_raddr    = deep ? idx : {r_a2[15:12], idx[3:0]};

    always_comb begin
        chr_we     = 1'b0;
        chr_waddr  = CHAR_AW'(i_req.address);
        chr_wdata  = i_req.write_data[7:0];
        pal_we     = 1'b0;
        pal_waddr  = i_req.address[PAL_AW-1:0];
        pal_wdata  = i_req.write_data[15:0];
        line_we    = 1'b0;
        line_waddr = i_req.address[LINE_AW-1:0];
        line_wdata = i_req.write_data;
        line_raddr = i_req.address[LINE_AW-1:0];
        case (r_state)
            S_CLR: begin
                chr_we     = 1'b1;
                chr_waddr  = r_clr;
                chr_wdata  = 8'd0;
                pal_we     = (r_clr < CHAR_AW'(PALETTE_ENTRIES));
                pal_waddr  = r_clr[PAL_AW-1:0];
                pal_wdata  = 16'd0;
                line_we    = (r_clr < CHAR_AW'(LINE_WIDTH));
                line_waddr = r_clr[LINE_AW-1:0];
                line_wdata = '0;
            end
            S_IDLE: begin
                chr_we  = acc && (i_req.op == OP_WR_CHR);
                pal_we  = acc && (i_req.op == OP_WR_PAL);
                line_we = acc && (i_req.op == OP_WR_LINE) && addr_in_line;
            end
            S_RD: begin
                line_raddr = r_pos;
            end
            S_CHR: begin
                line_raddr = r_copy ? LINE_AW'(r_pos - 1'b1) : r_pos;
            end
            S_PLT: begin
                line_we    = plot_we;
                line_waddr = r_pos;
                line_wdata = plot_data;
                line_raddr = r_pos;
            end
            default: begin
                line_raddr = r_pos;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (chr_we) begin
            r_chr_mem[chr_waddr] <= chr_wdata;
        end
        r_chr_q <= r_chr_mem[chr_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (pal_we) begin
            r_pal_mem[pal_waddr] <= pal_wdata;
        end
        r_pal_q <= r_pal_mem[pal_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (line_we) begin
            r_line_mem[line_waddr] <= line_wdata;
        end
        r_line_q <= r_line_mem[line_raddr];
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.pixel_word = r_out;

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_out       <= '0;
        end else begin
            // A read in progress reloads the output register itself.
            if (r_out_valid && o_rsp.ready && (r_state != S_RD)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == CHAR_AW'(CHAR_BYTES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (acc) begin
                        r_a0    <= i_req.attr_shape;
                        r_a1    <= i_req.attr_position;
                        r_a2    <= i_req.attr_tile;
                        r_line  <= i_req.scan_line;
                        r_pa    <= i_req.affine_pa;
                        r_pb    <= i_req.affine_pb;
                        r_pc    <= i_req.affine_pc;
                        r_pd    <= i_req.affine_pd;
                        r_aff   <= (i_req.op == OP_DRAW_AFF);
                        r_pos   <= i_req.address[LINE_AW-1:0];
                        r_rd_ok <= addr_in_line;
                        if (i_req.op == OP_RD_PIX) begin
                            r_state <= S_RD;
                        end else if ((i_req.op == OP_DRAW) || (i_req.op == OP_DRAW_AFF)) begin
                            r_state <= S_CHK;
                        end
                    end
                end
                S_RD: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out_valid <= 1'b1;
                        r_out       <= r_rd_ok ? r_line_q : '0;
                        r_state     <= S_IDLE;
                    end
                end
                S_CHK: begin
                    r_mos_w <= (r_a0[12] && (r_mos_h != 4'd0)) ? (5'(r_mos_h) + 5'd1) : 5'd0;
                    r_pmod  <= 4'd0;
                    r_linem <= r_line;
                    if (skip || (yoff > line_s) || (ytop_end <= line_s)) begin
                        r_state <= S_IDLE;
                    end else if (r_a0[12]) begin
                        r_dnd   <= r_line;
                        r_dvs   <= 5'(r_mos_v) + 5'd1;
                        r_rem   <= 4'd0;
                        r_dcnt  <= 3'd0;
                        r_dsel  <= 1'b0;
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_SET;
                    end
                end
                S_DIV: begin
                    r_dcnt <= r_dcnt + 3'd1;
                    if (r_dcnt != 3'd7) begin
                        r_rem <= d_rem_n;
                        r_dnd <= {r_dnd[6:0], 1'b0};
                    end else if (!r_dsel) begin
                        // Line snaps down to a multiple of the vertical mosaic size.
                        r_linem <= r_line - {4'b0, d_rem_n};
                        if (r_mos_w != 5'd0) begin
                            r_dnd  <= xoff[8] ? 8'd0 : xoff[7:0];
                            r_dvs  <= r_mos_w;
                            r_rem  <= 4'd0;
                            r_dsel <= 1'b1;
                        end else begin
                            r_state <= S_SET;
                        end
                    end else begin
                        r_pmod  <= d_rem_n;
                        r_state <= S_SET;
                    end
                end
                S_SET: begin
                    r_i     <= 8'd0;
                    r_row   <= row_c;
                    r_dy    <= linem_s - yoff - $signed({4'b0, fh[7:1]});
                    r_cx    <= $signed({{(CX_W-14){1'b0}}, w8, 7'b0});
                    r_cy    <= $signed({{(CX_W-14){1'b0}}, h8, 7'b0});
                    r_mstep <= 3'd0;
                    r_state <= r_aff ? S_AFF : S_PIX;
                end
                S_AFF: begin
                    r_prod  <= mul_a * mul_b;
                    r_mstep <= r_mstep + 3'd1;
                    case (r_mstep)
                        3'd1:    r_cx <= r_cx - CX_W'(r_prod);
                        3'd2:    r_cx <= r_cx + CX_W'(r_prod);
                        3'd3:    r_cy <= r_cy - CX_W'(r_prod);
                        3'd4:    r_cy <= r_cy + CX_W'(r_prod);
                        default: ;
                    endcase
                    if (r_mstep == 3'd4) begin
                        r_state <= S_PIX;
                    end
                end
                S_PIX: begin
                    if (r_i == fw) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_i  <= r_i + 8'd1;
                        r_cx <= r_cx + CX_W'(r_pa);
                        r_cy <= r_cy + CX_W'(r_pc);
                        // Position modulo the horizontal mosaic size tracks the screen x.
                        if (!pos_u[10] && (r_mos_w != 5'd0)) begin
                            r_pmod <= (pmod_inc == r_mos_w) ? 4'd0 : pmod_inc[3:0];
                        end
                        r_pos  <= pos_u[LINE_AW-1:0];
                        r_sx0  <= sx[0];
                        r_copy <= copy;
                        if (do_plot) begin
                            r_state <= S_CHR;
                        end
                    end
                end
                S_CHR: begin
                    r_idx_nz <= (idx != 8'd0);
                    r_state  <= S_PLT;
                end
                S_PLT: begin
                    r_state <= S_PIX;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
